/* rtl/core/uhf_pkg.sv */
// Shared types and constants for the uniform histogram fill unit.
package uhf_pkg;

	localparam int unsigned CoordW = 32;
	localparam int unsigned NBinsW = 11;
	localparam int unsigned TotalW = 48;
	localparam int unsigned OffW   = 33;

	localparam logic signed [TotalW-1:0] TotalMax = {1'b0, {(TotalW-1){1'b1}}};
	localparam logic signed [TotalW-1:0] TotalMin = {1'b1, {(TotalW-1){1'b0}}};

	typedef enum logic [1:0] {
		CFG_X_MIN  = 2'd0,
		CFG_X_MAX  = 2'd1,
		CFG_N_BINS = 2'd2
	} cfg_idx_t;

	typedef enum logic [1:0] {
		DIV_IDLE,
		DIV_RUN,
		DIV_DONE
	} div_state_t;

endpackage

/* rtl/core/uhf_front.sv */
// Front end: range check and iterative bin-index divider.
module uhf_front #(
	parameter int unsigned MAX_BINS = 1024,
	parameter int unsigned IDX_W    = 10
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic signed [uhf_pkg::CoordW-1:0]     sample_value,
	input  logic signed [uhf_pkg::CoordW-1:0]     fill_weight,
	input  logic signed [uhf_pkg::CoordW-1:0]     x_min,
	input  logic signed [uhf_pkg::CoordW-1:0]     x_max,
	input  logic        [uhf_pkg::NBinsW-1:0]     n_bins,
	output logic                                  cls_valid,
	input  logic                                  cls_stall,
	output logic                                  cls_hit,
	output logic        [IDX_W-1:0]               cls_idx,
	output logic signed [uhf_pkg::CoordW-1:0]     cls_weight
);
	// Numerator is n*off: up to 17+33 bits.
	localparam int unsigned NW = uhf_pkg::OffW + 17;
	localparam int unsigned CW = $clog2(NW + 1);

	uhf_pkg::div_state_t state_q, state_d;
	logic [NW-1:0]               num_q;
	logic [uhf_pkg::OffW:0]      rem_q;
	logic [uhf_pkg::OffW-1:0]    den_q;
	logic [CW-1:0]               cnt_q;
	logic                        hit_q;
	logic [16:0]                 n_q;
	logic signed [uhf_pkg::CoordW-1:0] w_q;

	logic [16:0] n_eff;
	logic [uhf_pkg::OffW-1:0] off, rng;
	logic in_range, accept;
	logic [uhf_pkg::OffW:0] rem_sh;
	logic [uhf_pkg::OffW:0] rem_sub;
	logic [NW-1:0] quo;

	always_comb begin
		if (n_bins > uhf_pkg::NBinsW'(MAX_BINS > 2047 ? 2047 : MAX_BINS))
			n_eff = 17'(MAX_BINS);
		else
			n_eff = 17'(n_bins);
		off = 33'(signed'({sample_value[31], sample_value}) - signed'({x_min[31], x_min}));
		rng = 33'(signed'({x_max[31], x_max}) - signed'({x_min[31], x_min}));
		in_range = (n_eff != '0) && (sample_value >= x_min) && (sample_value < x_max);
	end

	assign in_stall = (state_q != uhf_pkg::DIV_IDLE);
	assign accept   = in_valid && !in_stall;

	// Restoring divider: one quotient bit per cycle, shifted into num_q.
	always_comb begin
		rem_sh  = {rem_q[uhf_pkg::OffW-1:0], num_q[NW-1]};
		rem_sub = rem_sh - {1'b0, den_q};
		quo     = num_q;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			uhf_pkg::DIV_IDLE: begin
				if (accept) state_d = in_range ? uhf_pkg::DIV_RUN : uhf_pkg::DIV_DONE;
			end
			uhf_pkg::DIV_RUN: begin
				if (cnt_q == CW'(NW - 1)) state_d = uhf_pkg::DIV_DONE;
			end
			uhf_pkg::DIV_DONE: begin
				if (!cls_stall) state_d = uhf_pkg::DIV_IDLE;
			end
			default: state_d = uhf_pkg::DIV_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= uhf_pkg::DIV_IDLE;
		else         state_q <= state_d;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			num_q <= NW'(off) * NW'(n_eff);
			rem_q <= '0;
			den_q <= rng;
			cnt_q <= '0;
			hit_q <= in_range;
			n_q   <= n_eff;
			w_q   <= fill_weight;
		end else if (state_q == uhf_pkg::DIV_RUN) begin
			cnt_q <= cnt_q + 1'b1;
			if (!rem_sub[uhf_pkg::OffW]) begin
				rem_q <= rem_sub;
				num_q <= {num_q[NW-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				num_q <= {num_q[NW-2:0], 1'b0};
			end
		end
	end

	assign cls_valid  = (state_q == uhf_pkg::DIV_DONE);
	assign cls_hit    = hit_q;
	assign cls_weight = w_q;
	// Clamp index to n-1 (exact math never exceeds it).
	assign cls_idx = (quo >= NW'(n_q)) ? IDX_W'(n_q - 17'd1) : IDX_W'(quo);
endmodule

/* rtl/core/uhf_queue.sv */
// Two-entry queue between the classifier and the bin updater.
module uhf_queue #(
	parameter int unsigned W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         wr_valid,
	output logic         wr_stall,
	input  logic [W-1:0] wr_data,
	output logic         rd_valid,
	input  logic         rd_stall,
	output logic [W-1:0] rd_data
);
	logic [W-1:0] mem_q [2];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;
	logic push, pop;

	assign wr_stall = (cnt_q == 2'd2);
	assign rd_valid = (cnt_q != 2'd0);
	assign push = wr_valid && !wr_stall;
	assign pop  = rd_valid && !rd_stall;
	assign rd_data = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= '0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop)  rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= wr_data;
	end
endmodule

/* rtl/core/uhf_back.sv */
// Back end: bin store read-modify-write with saturation and clearing pass.
module uhf_back #(
	parameter int unsigned MAX_BINS = 1024,
	parameter int unsigned IDX_W    = 10
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               req_valid,
	output logic                               req_stall,
	input  logic                               req_hit,
	input  logic        [IDX_W-1:0]            req_idx,
	input  logic signed [uhf_pkg::CoordW-1:0]  req_weight,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic                               accepted,
	output logic        [uhf_pkg::NBinsW-1:0]  bin_number,
	output logic signed [uhf_pkg::TotalW-1:0]  bin_total
);
	logic signed [uhf_pkg::TotalW-1:0] store_q [MAX_BINS];
	logic                              clr_q;
	logic [IDX_W-1:0]                  clr_idx_q;
	logic                              rd_s1;
	logic                              hit_s1;
	logic [IDX_W-1:0]                  idx_s1;
	logic signed [uhf_pkg::CoordW-1:0] w_s1;
	logic signed [uhf_pkg::TotalW-1:0] data_s1;
	logic                              ov_q;
	logic signed [uhf_pkg::TotalW:0]   sum;
	logic signed [uhf_pkg::TotalW-1:0] sat;
	logic take, fin;

	// One item in the read stage at a time; output register must be free.
	assign req_stall = clr_q || rd_s1 || (ov_q && out_stall);
	assign take = req_valid && !req_stall;
	assign fin  = rd_s1 && (!ov_q || !out_stall);

	always_comb begin
		sum = (uhf_pkg::TotalW+1)'(data_s1) + (uhf_pkg::TotalW+1)'(w_s1);
		if (sum > (uhf_pkg::TotalW+1)'(uhf_pkg::TotalMax))
			sat = uhf_pkg::TotalMax;
		else if (sum < (uhf_pkg::TotalW+1)'(uhf_pkg::TotalMin))
			sat = uhf_pkg::TotalMin;
		else
			sat = sum[uhf_pkg::TotalW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= 1'b1; clr_idx_q <= '0; rd_s1 <= 1'b0; ov_q <= 1'b0;
		end else begin
			if (clr_q) begin
				clr_idx_q <= clr_idx_q + 1'b1;
				if (clr_idx_q == IDX_W'(MAX_BINS - 1)) clr_q <= 1'b0;
			end
			if (take)     rd_s1 <= 1'b1;
			else if (fin) rd_s1 <= 1'b0;
			if (fin)                ov_q <= 1'b1;
			else if (!out_stall)    ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (clr_q) store_q[clr_idx_q] <= '0;
		else if (fin && hit_s1) store_q[idx_s1] <= sat;
		if (take) begin
			data_s1 <= store_q[req_idx];
			hit_s1  <= req_hit;
			idx_s1  <= req_idx;
			w_s1    <= req_weight;
		end
		if (fin) begin
			accepted   <= hit_s1;
			bin_number <= hit_s1 ? uhf_pkg::NBinsW'({1'b0, idx_s1} + 1'b1) : '0;
			bin_total  <= hit_s1 ? sat : '0;
		end
	end

	assign out_valid = ov_q;
endmodule

/* rtl/core/uniform_histogram_fill_unit.sv */
// Top level of the uniform histogram fill unit.
// Fixed-width 1-D histogram: each request (sample_value, fill_weight, Q16.16)
// gives one result. In-range samples add the weight to bin
// 1 + floor(n_bins*(x-x_min)/(x_max-x_min)), saturating at 48 bits; others
// return all zeros. An in-range request holds the input while the bit-serial
// divider produces one quotient bit per cycle over a 50-bit numerator, and
// then until the queue takes the result; a rejected request skips the divider.
// The result then passes through the queue and the bin read-modify-write.
// After reset a clearing pass zeroes the bin store before the first bin update.
module uniform_histogram_fill_unit #(
	parameter int unsigned MAX_BINS = 1024
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic        [1:0]                  cfg_index,
	input  logic        [31:0]                 cfg_data,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic signed [uhf_pkg::CoordW-1:0]  sample_value,
	input  logic signed [uhf_pkg::CoordW-1:0]  fill_weight,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic                               accepted,
	output logic        [uhf_pkg::NBinsW-1:0]  bin_number,
	output logic signed [uhf_pkg::TotalW-1:0]  bin_total
);
	localparam int unsigned IDX_W = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
	localparam int unsigned QW = 1 + IDX_W + uhf_pkg::CoordW;

	logic signed [31:0] x_min_q, x_max_q;
	logic [uhf_pkg::NBinsW-1:0] n_bins_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_min_q  <= 32'sd0;
			x_max_q  <= 32'sd67108864;
			n_bins_q <= 11'd1024;
		end else if (cfg_we) begin
			case (cfg_index)
				uhf_pkg::CFG_X_MIN:  x_min_q  <= cfg_data;
				uhf_pkg::CFG_X_MAX:  x_max_q  <= cfg_data;
				uhf_pkg::CFG_N_BINS: n_bins_q <= cfg_data[uhf_pkg::NBinsW-1:0];
				default: ;
			endcase
		end
	end

	logic cls_valid, cls_stall, cls_hit;
	logic [IDX_W-1:0] cls_idx;
	logic signed [31:0] cls_weight;
	logic q_valid, q_stall;
	logic [QW-1:0] q_data;

	uhf_front #(.MAX_BINS(MAX_BINS), .IDX_W(IDX_W)) u_front (
		.clk, .arst_n, .in_valid, .in_stall, .sample_value, .fill_weight,
		.x_min(x_min_q), .x_max(x_max_q), .n_bins(n_bins_q),
		.cls_valid, .cls_stall, .cls_hit, .cls_idx, .cls_weight
	);

	uhf_queue #(.W(QW)) u_queue (
		.clk, .arst_n,
		.wr_valid(cls_valid), .wr_stall(cls_stall),
		.wr_data({cls_hit, cls_idx, cls_weight}),
		.rd_valid(q_valid), .rd_stall(q_stall), .rd_data(q_data)
	);

	uhf_back #(.MAX_BINS(MAX_BINS), .IDX_W(IDX_W)) u_back (
		.clk, .arst_n,
		.req_valid(q_valid), .req_stall(q_stall),
		.req_hit(q_data[QW-1]), .req_idx(q_data[QW-2:uhf_pkg::CoordW]),
		.req_weight(q_data[uhf_pkg::CoordW-1:0]),
		.out_valid, .out_stall, .accepted, .bin_number, .bin_total
	);
endmodule

/* tb/uhf_fill_checker.sv */
// Scoreboard for the histogram fill unit: predicts each result and compares it.
module uhf_fill_checker (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic        [1:0]                  cfg_index,
	input  logic        [31:0]                 cfg_data,
	input  logic                               in_valid,
	input  logic                               in_stall,
	input  logic signed [uhf_pkg::CoordW-1:0]  sample_value,
	input  logic signed [uhf_pkg::CoordW-1:0]  fill_weight,
	input  logic                               out_valid,
	input  logic                               out_stall,
	input  logic                               accepted,
	input  logic        [uhf_pkg::NBinsW-1:0]  bin_number,
	input  logic signed [uhf_pkg::TotalW-1:0]  bin_total,
	output int                                 fails,
	output int                                 pending,
	output int                                 fills_seen,
	output int                                 rejects_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int HistBins = 1024;

	typedef struct packed {
		logic                              hit;
		logic [uhf_pkg::NBinsW-1:0]        bin;
		logic signed [uhf_pkg::TotalW-1:0] total;
	} fill_result_t;

	logic signed [uhf_pkg::CoordW-1:0] lo_edge;
	logic signed [uhf_pkg::CoordW-1:0] hi_edge;
	logic        [uhf_pkg::NBinsW-1:0] bin_count;
	logic signed [uhf_pkg::TotalW-1:0] bin_content [HistBins];
	fill_result_t                      expected_fills [$];

	function automatic fill_result_t predict_fill(logic signed [uhf_pkg::CoordW-1:0] x,
			logic signed [uhf_pkg::CoordW-1:0] w);
		fill_result_t r;
		longint n, off, span, idx, sum;
		r = '0;
		n = (bin_count > HistBins) ? HistBins : bin_count;
		if (n == 0 || x < lo_edge || x >= hi_edge)
			return r;
		off  = longint'(x) - longint'(lo_edge);
		span = longint'(hi_edge) - longint'(lo_edge);
		idx  = (n * off) / span;
		if (idx >= n)
			idx = n - 1;
		sum = longint'(bin_content[idx]) + longint'(w);
		if (sum > longint'(uhf_pkg::TotalMax))
			sum = longint'(uhf_pkg::TotalMax);
		if (sum < longint'(uhf_pkg::TotalMin))
			sum = longint'(uhf_pkg::TotalMin);
		bin_content[idx] = sum[uhf_pkg::TotalW-1:0];
		r.hit   = 1'b1;
		r.bin   = uhf_pkg::NBinsW'(idx + 1);
		r.total = sum[uhf_pkg::TotalW-1:0];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		fill_result_t want;
		fill_result_t got;
		if (!arst_n) begin
			lo_edge   <= '0;
			hi_edge   <= 32'sd67108864;
			bin_count <= 11'd1024;
			for (int i = 0; i < HistBins; i++)
				bin_content[i] = '0;
			expected_fills.delete();
			fails        <= 0;
			pending      <= 0;
			fills_seen   <= 0;
			rejects_seen <= 0;
		end else begin
			if (cfg_we) begin
				case (uhf_pkg::cfg_idx_t'(cfg_index))
					uhf_pkg::CFG_X_MIN:  lo_edge   <= cfg_data;
					uhf_pkg::CFG_X_MAX:  hi_edge   <= cfg_data;
					uhf_pkg::CFG_N_BINS: bin_count <= cfg_data[uhf_pkg::NBinsW-1:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				expected_fills.push_back(predict_fill(sample_value, fill_weight));
			if (out_valid && !out_stall) begin
				got = '{accepted, bin_number, bin_total};
				if (expected_fills.size() == 0) begin
					if (fails < 10)
						$display("%0t: unexpected result hit=%0b bin=%0d total=%0d",
							$realtime, accepted, bin_number, bin_total);
					fails <= fails + 1;
				end else begin
					want = expected_fills.pop_front();
					if (want !== got) begin
						if (fails < 10)
							$display("%0t: mismatch exp hit=%0b bin=%0d total=%0d, got hit=%0b bin=%0d total=%0d",
								$realtime, want.hit, want.bin, want.total,
								got.hit, got.bin, got.total);
						fails <= fails + 1;
					end
					if (want.hit)
						fills_seen <= fills_seen + 1;
					else
						rejects_seen <= rejects_seen + 1;
				end
			end
			pending <= expected_fills.size();
		end
	end

endmodule

/* tb/testbench.sv */
// Stimulus and verdict for the histogram fill unit.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int Drain = 80;

	logic                               clk;
	logic                               arst_n;
	logic                               cfg_we;
	logic        [1:0]                  cfg_index;
	logic        [31:0]                 cfg_data;
	logic                               in_valid;
	logic                               in_stall;
	logic signed [uhf_pkg::CoordW-1:0]  sample_value;
	logic signed [uhf_pkg::CoordW-1:0]  fill_weight;
	logic                               out_valid;
	logic                               out_stall;
	logic                               accepted;
	logic        [uhf_pkg::NBinsW-1:0]  bin_number;
	logic signed [uhf_pkg::TotalW-1:0]  bin_total;
	int                                 fails, pending, fills_seen, rejects_seen;
	int                                 stall_left, calm_left;
	int                                 phases_run;
	longint                             lo_cur, hi_cur;

	uniform_histogram_fill_unit dut (.*);

	uhf_fill_checker u_checker (.*);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#40_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	// response-side backpressure: bursts of stall, with calm stretches
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall  <= 1'b0;
			stall_left <= 0;
			calm_left  <= 0;
		end else if (calm_left > 0) begin
			calm_left <= calm_left - 1;
			out_stall <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_stall  <= 1'b1;
		end else begin
			case ($urandom_range(0, 19))
				0:       calm_left  <= $urandom_range(200, 800);
				1, 2:    stall_left <= $urandom_range(10, 80);
				3, 4, 5: stall_left <= $urandom_range(1, 4);
				default: ;
			endcase
			out_stall <= 1'b0;
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(5, 60);
	endfunction

	task automatic send_fill(logic signed [31:0] x, logic signed [31:0] w);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid     <= 1'b1;
		sample_value <= x;
		fill_weight  <= w;
		do @(posedge clk); while (in_stall);
	endtask

	// hold requests until every outstanding result is back
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (Drain) @(posedge clk);
	endtask

	task automatic set_range(logic signed [31:0] lo, logic signed [31:0] hi,
			logic [10:0] n);
		drain();
		cfg_we <= 1'b1;
		cfg_index <= uhf_pkg::CFG_X_MIN;
		cfg_data <= lo;
		@(posedge clk);
		cfg_index <= uhf_pkg::CFG_X_MAX;
		cfg_data <= hi;
		@(posedge clk);
		cfg_index <= uhf_pkg::CFG_N_BINS;
		cfg_data <= {21'b0, n};
		@(posedge clk);
		cfg_we <= 1'b0;
		lo_cur = longint'(lo);
		hi_cur = longint'(hi);
		phases_run++;
	endtask

	function automatic logic [31:0] rand_weight();
		case ($urandom_range(0, 9))
			0:       return 32'h7FFF_FFFF;
			1:       return 32'h8000_0000;
			2:       return 32'd65536;
			3:       return -32'sd65536;
			4:       return 32'd0;
			5, 6:    return $urandom_range(0, 20) * 32'd65536;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [31:0] rand_sample();
		int r;
		longint span;
		r = $urandom_range(0, 99);
		span = hi_cur - lo_cur;
		if (span > 0 && r < 70)
			return 32'(lo_cur + ({$urandom, $urandom} % span));
		case (r % 5)
			0: return 32'(lo_cur);
			1: return 32'(hi_cur - 1);
			2: return 32'(hi_cur);
			3: return 32'(lo_cur - 1);
			default: return $urandom;
		endcase
	endfunction

	task automatic random_fills(int count);
		for (int i = 0; i < count; i++)
			send_fill(rand_sample(), rand_weight());
	endtask

	initial begin
		logic signed [31:0] lo, hi;
		arst_n       = 1'b0;
		cfg_we       = 1'b0;
		cfg_index    = uhf_pkg::CFG_X_MIN;
		cfg_data     = '0;
		in_valid     = 1'b0;
		sample_value = '0;
		fill_weight  = '0;
		phases_run   = 0;
		lo_cur       = 0;
		hi_cur       = 67108864;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset range: 0.0 .. 1024.0 over 1024 bins
		send_fill(32'sd0, 32'sd65536);
		send_fill(32'sd0, 32'sd65536);
		send_fill(32'sd67108863, 32'h7FFF_FFFF);
		send_fill(32'sd67108863, 32'h8000_0000);
		send_fill(32'sd67108864, 32'sd65536);
		send_fill(-32'sd1, 32'sd65536);
		send_fill(32'h7FFF_FFFF, 32'sd65536);
		send_fill(32'h8000_0000, 32'sd65536);
		send_fill(32'sd819200, 32'sd0);
		send_fill(32'sd819200, -32'sd98304);

		// full span, widest range the registers allow
		set_range(32'h8000_0000, 32'h7FFF_FFFF, 11'd1024);
		send_fill(32'h8000_0000, 32'h7FFF_FFFF);
		send_fill(32'h7FFF_FFFE, 32'h8000_0000);
		send_fill(32'h7FFF_FFFF, 32'sd65536);
		send_fill(32'sd0, 32'sd65536);
		// single bin
		set_range(-32'sd65536, 32'sd65536, 11'd1);
		send_fill(-32'sd65536, 32'sd65536);
		send_fill(32'sd65535, 32'sd65536);
		// zero bins: all rejected
		set_range(32'sd0, 32'sd65536, 11'd0);
		send_fill(32'sd100, 32'sd65536);
		// bin count above capacity clamps to the largest
		set_range(32'sd0, 32'sd1024, 11'd2047);
		send_fill(32'sd1023, 32'sd65536);
		send_fill(32'sd0, 32'sd65536);
		// inverted and empty ranges
		set_range(32'sd65536, -32'sd65536, 11'd8);
		send_fill(32'sd0, 32'sd65536);
		set_range(32'sd65536, 32'sd65536, 11'd8);
		send_fill(32'sd65536, 32'sd65536);

		// random phases
		for (int p = 0; p < 14; p++) begin
			case (p % 7)
				0: begin lo = 32'h8000_0000; hi = 32'h7FFF_FFFF; end
				1: begin lo = $urandom; hi = $urandom; end
				2: begin lo = -$urandom_range(0, 1 << 24); hi = $urandom_range(1, 1 << 24); end
				3: begin lo = $urandom; hi = lo + $urandom_range(1, 3000); end
				default: begin lo = -$urandom_range(0, 1 << 26); hi = $urandom_range(0, 1 << 26); end
			endcase
			if (hi <= lo && $urandom_range(0, 3) != 0) begin
				lo = -$urandom_range(1, 1 << 20);
				hi = $urandom_range(1, 1 << 20);
			end
			case ($urandom_range(0, 9))
				0:       set_range(lo, hi, 11'd0);
				1:       set_range(lo, hi, 11'($urandom_range(1025, 2047)));
				2:       set_range(lo, hi, 11'd1);
				3:       set_range(lo, hi, 11'd1024);
				default: set_range(lo, hi, 11'($urandom_range(1, 1024)));
			endcase
			random_fills(p == 13 ? 150 : 120);
		end

		drain();
		$display("Ran %0d range settings: %0d bin fills and %0d rejected samples checked.",
			phases_run, fills_seen, rejects_seen);
		if (fails == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
